@@ design/remote_packet_receiver_assert.svh @@
// Assertion macros used by the remote packet receiver checker.
`ifndef REMOTE_PACKET_RECEIVER_ASSERT_SVH
`define REMOTE_PACKET_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ design/rpr_pkg.sv @@
// Package: types, constants and helpers of the remote packet receiver.
package rpr_pkg;

    localparam int CfgAddrW = 3;

    localparam logic [0:0] REG_DEFAULT_DATA  = 1'b0;
    localparam logic [0:0] REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    localparam logic        OP_BYTE = 1'b0;
    localparam logic        OP_TICK = 1'b1;

    localparam logic [7:0]  START_BYTE = 8'h2A;
    localparam logic [3:0]  HEADER_LEN = 4'd3;
    localparam logic [3:0]  WORD_FIRST = 4'd5;
    localparam logic [3:0]  WORD_LAST  = 4'd8;

    typedef struct packed {
        logic [31:0] default_data;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [31:0] control_word;
        logic        link_ok;
        logic        packet_done;
        logic        timed_out;
    } result_t;

    // Expected header character "DR=" by body position.
    function automatic logic [7:0] header_char(input logic [1:0] pos);
        logic [7:0] c;
        unique case (pos)
            2'd0:    c = 8'h44;
            2'd1:    c = 8'h52;
            2'd2:    c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

@@ design/rpr_regs.sv @@
// Configuration registers with APB-style write and read access.
module rpr_regs
    import rpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_DEFAULT_DATA:  cfg_next.default_data  = pwdata;
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = pwdata[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.default_data  <= 32'd0;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_DEFAULT_DATA:  prdata = cfg_reg.default_data;
            REG_TIMEOUT_TICKS: prdata = {16'd0, cfg_reg.timeout_ticks};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ design/rpr_core.sv @@
// Packet parser state, silence timer and per-transfer result logic.
module rpr_core
    import rpr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       item_en,
    input  logic       operation,
    input  logic [7:0] byte_value,
    input  cfg_t       cfg,
    output result_t    result
);

    logic        in_packet_reg,      in_packet_next;
    logic [3:0]  byte_position_reg,  byte_position_next;
    logic [23:0] partial_word_reg,   partial_word_next;
    logic [31:0] received_word_reg,  received_word_next;
    logic        using_received_reg, using_received_next;
    logic        link_flag_reg,      link_flag_next;
    logic [15:0] silence_count_reg,  silence_count_next;
    logic [15:0] silence_inc;
    logic        done;
    logic        tout;

    assign silence_inc = (silence_count_reg == 16'hFFFF) ? silence_count_reg
                                                          : silence_count_reg + 16'd1;

    always_comb begin
        in_packet_next      = in_packet_reg;
        byte_position_next  = byte_position_reg;
        partial_word_next   = partial_word_reg;
        received_word_next  = received_word_reg;
        using_received_next = using_received_reg;
        link_flag_next      = link_flag_reg;
        silence_count_next  = silence_count_reg;
        done                = 1'b0;
        tout                = 1'b0;

        if (operation == OP_TICK) begin
            silence_count_next = silence_inc;
            if (silence_inc >= cfg.timeout_ticks) begin
                using_received_next = 1'b0;
                silence_count_next  = 16'd0;
                tout                = 1'b1;
            end
        end else if (!in_packet_reg) begin
            if (byte_value == START_BYTE) begin
                in_packet_next     = 1'b1;
                byte_position_next = 4'd0;
            end
        end else if (byte_position_reg < HEADER_LEN) begin
            if (byte_value != header_char(byte_position_reg[1:0])) begin
                in_packet_next = 1'b0;
                link_flag_next = 1'b0;
            end else begin
                byte_position_next = byte_position_reg + 4'd1;
            end
        end else if (byte_position_reg >= WORD_LAST) begin
            received_word_next  = {byte_value, partial_word_reg};
            using_received_next = 1'b1;
            link_flag_next      = 1'b1;
            silence_count_next  = 16'd0;
            in_packet_next      = 1'b0;
            done                = 1'b1;
        end else begin
            if (byte_position_reg >= WORD_FIRST) begin
                unique case (byte_position_reg)
                    4'd5:    partial_word_next[7:0]   = byte_value;
                    4'd6:    partial_word_next[15:8]  = byte_value;
                    default: partial_word_next[23:16] = byte_value;
                endcase
            end
            byte_position_next = byte_position_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_packet_reg      <= 1'b0;
            byte_position_reg  <= 4'd0;
            using_received_reg <= 1'b0;
            link_flag_reg      <= 1'b0;
            silence_count_reg  <= 16'd0;
        end else if (item_en) begin
            in_packet_reg      <= in_packet_next;
            byte_position_reg  <= byte_position_next;
            using_received_reg <= using_received_next;
            link_flag_reg      <= link_flag_next;
            silence_count_reg  <= silence_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            partial_word_reg  <= partial_word_next;
            received_word_reg <= received_word_next;
        end
    end

    assign result.control_word = using_received_next ? received_word_next
                                                     : cfg.default_data;
    assign result.link_ok      = link_flag_next;
    assign result.packet_done  = done;
    assign result.timed_out    = tout;

endmodule

@@ design/rpr_out_buf.sv @@
// Two-entry output register with skid stage for the result channel.
module rpr_out_buf
    import rpr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg,  main_data_next;
    result_t skid_data_reg,  skid_data_next;
    logic    in_fire;

    assign in_ready = ~skid_valid_reg;
    assign in_fire  = in_valid & in_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                main_data_next  = in_data;
                main_valid_next = in_fire;
            end
        end else if (in_fire) begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

@@ design/remote_packet_receiver.sv @@
// Top level of the remote packet receiver.
//
// Input stream: one transfer per received serial byte (s_tuser = 0) or per
// timer tick (s_tuser = 1). Bytes are parsed as '*' followed by "DR=", two
// ignored bytes and a 32-bit control word, least significant byte first.
// Output stream: exactly one result transfer per input transfer, carrying
// the current control word, the link flag, a packet-complete mark (tlast)
// and a timeout mark.
// Each result is registered in the output buffer before it appears on m_*.
// Throughput: one transfer per cycle while s_tready is high; all parsing is
// one level of logic between the parser state registers and the output register.
// Stall: a two-entry output buffer holds results while m_tready is low;
// s_tready drops only once both entries are full.
// Reset (aresetn low, synchronous): parser hunts for '*', default word
// selected, link flag and silence counter cleared, output buffer empty,
// default_data = 0 and timeout_ticks = 500. APB: default_data at 0x0,
// timeout_ticks at 0x4, written only when idle: a user rule, unenforced.
module remote_packet_receiver
    import rpr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] byte_value
    input  logic                s_tuser,   // [0] operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [31:0] control_word
    output logic [1:0]          m_tuser,   // [0] link_ok, [1] timed_out
    output logic                m_tlast,   // packet_done
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cfg_t    cfg;
    result_t core_result;
    result_t out_result;
    logic    item_en;

    assign pready  = 1'b1;
    assign item_en = s_tvalid & s_tready;

    rpr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    rpr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_en    (item_en),
        .operation  (s_tuser),
        .byte_value (s_tdata),
        .cfg        (cfg),
        .result     (core_result)
    );

    rpr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (core_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = out_result.control_word;
    assign m_tuser = {out_result.timed_out, out_result.link_ok};
    assign m_tlast = out_result.packet_done;

endmodule

@@ design/rpr_checker.sv @@
// Port-level checker for the remote packet receiver, bound to the top level.
`include "remote_packet_receiver_assert.svh"

module rpr_checker
    import rpr_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `RPR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `RPR_ASSERT_NOW(a_done_sets_link, aclk, aresetn, m_tvalid && m_tlast, m_tuser[0])
    `RPR_ASSERT_NOW(a_done_not_timeout, aclk, aresetn, m_tvalid && m_tlast, !m_tuser[1])
    `RPR_ASSERT_NOW(a_full_has_output, aclk, aresetn, !s_tready, m_tvalid)

endmodule

bind remote_packet_receiver rpr_checker u_rpr_checker (.*);

@@ tb/remote_packet_receiver_tb.sv @@
// Self-checking testbench for remote_packet_receiver: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 100ps

module remote_packet_receiver_tb;
    import rpr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 325;
    localparam int HOLD_CYCLES = 60;
    localparam logic [7:0] HDR_TEXT [3] = '{8'h44, 8'h52, 8'h3D};

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } rx_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // [7:0] byte_value
    logic        s_tuser = 1'b0;    // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] control_word
    logic [1:0]  m_tuser;           // [0] link_ok, [1] timed_out
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [CfgAddrW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    remote_packet_receiver u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    rx_item_t pending_items[$];
    result_t  expected_words[$];
    int       idle_pct = 0;
    int       stall_pct = 0;
    logic     hold_off = 1'b0;
    int       n_queued = 0;
    int       n_checked = 0;
    int       mismatches = 0;
    int       cycle_count = 0;

    // receiver state as predicted
    logic [31:0] cfg_default = 32'd0;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic        rx_in_frame = 1'b0;
    logic [3:0]  rx_pos = '0;
    logic [23:0] rx_partial = '0;
    logic [31:0] rx_word = '0;
    logic        rx_use_word = 1'b0;
    logic        rx_link = 1'b0;
    logic [15:0] rx_silence = '0;

    function automatic void predict_control(input logic op, input logic [7:0] b);
        result_t r;
        r.packet_done = 1'b0;
        r.timed_out = 1'b0;
        if (op == OP_BYTE) begin
            if (!rx_in_frame) begin
                if (b == START_BYTE) begin
                    rx_in_frame = 1'b1;
                    rx_pos = '0;
                end
            end else if (rx_pos < HEADER_LEN) begin
                if (b != HDR_TEXT[rx_pos]) begin
                    rx_in_frame = 1'b0;
                    rx_link = 1'b0;
                end else begin
                    rx_pos = rx_pos + 4'd1;
                end
            end else if (rx_pos >= WORD_LAST) begin
                rx_word = {b, rx_partial};
                rx_use_word = 1'b1;
                rx_link = 1'b1;
                rx_silence = '0;
                rx_in_frame = 1'b0;
                r.packet_done = 1'b1;
            end else begin
                if (rx_pos >= WORD_FIRST)
                    rx_partial[(rx_pos - WORD_FIRST) * 8 +: 8] = b;
                rx_pos = rx_pos + 4'd1;
            end
        end else begin
            if (rx_silence != 16'hFFFF)
                rx_silence = rx_silence + 16'd1;
            if (rx_silence >= cfg_timeout) begin
                rx_use_word = 1'b0;
                rx_silence = '0;
                r.timed_out = 1'b1;
            end
        end
        r.control_word = rx_use_word ? rx_word : cfg_default;
        r.link_ok = rx_link;
        expected_words.push_back(r);
    endfunction

    // sender
    always @(posedge aclk) begin
        rx_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_control(s_tuser, s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    it = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= it.op;
                    s_tdata <= it.value;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: stall and check
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.control_word = m_tdata;
                got.link_ok = m_tuser[0];
                got.packet_done = m_tlast;
                got.timed_out = m_tuser[1];
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transfer: word=%h link=%b done=%b tout=%b",
                                 got.control_word, got.link_ok, got.packet_done,
                                 got.timed_out);
                end else begin
                    want = expected_words.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"result %0d: word exp %h got %h, link exp %b got %b,",
                                      " done exp %b got %b, tout exp %b got %b"},
                                     n_checked, want.control_word, got.control_word,
                                     want.link_ok, got.link_ok, want.packet_done,
                                     got.packet_done, want.timed_out, got.timed_out);
                    end
                end
                n_checked++;
            end
            m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void push_item(input logic op, input logic [7:0] v);
        rx_item_t it;
        it.op = op;
        it.value = v;
        pending_items.push_back(it);
        n_queued++;
    endfunction

    function automatic int push_tick();
        push_item(OP_TICK, 8'($urandom));
        return 1;
    endfunction

    // Start byte plus nine body bytes; bad_at < 3 corrupts that header byte
    // and ends the frame there.
    function automatic int push_frame(input logic [31:0] word, input int bad_at);
        logic [7:0] body [9];
        int n;
        n = 1;
        body = '{HDR_TEXT[0], HDR_TEXT[1], HDR_TEXT[2], 8'($urandom), 8'($urandom),
                 word[7:0], word[15:8], word[23:16], word[31:24]};
        if (bad_at < 3)
            body[bad_at] = body[bad_at] ^ 8'($urandom_range(1, 255));
        push_item(OP_BYTE, START_BYTE);
        for (int i = 0; i < 9; i++) begin
            if (bad_at < 3 && i > bad_at)
                break;
            if ($urandom_range(9) == 0)
                n += push_tick();
            push_item(OP_BYTE, body[i]);
            n++;
        end
        return n;
    endfunction

    function automatic logic [31:0] pick_word();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            return 32'h0000_0000;
        if (k == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic apb_write(input logic [0:0] reg_id, input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_id, 2'b00};
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_id == REG_DEFAULT_DATA)
            cfg_default = v;
        else
            cfg_timeout = v[15:0];
    endtask

    task automatic drain();
        while (n_checked != n_queued)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_config(input logic [31:0] dflt, input logic [15:0] tmo);
        apb_write(REG_DEFAULT_DATA, dflt);
        apb_write(REG_TIMEOUT_TICKS, {16'($urandom), tmo});
    endtask

    logic [31:0] phase_default [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                                       32'hA5A5_0F0F, 32'h8000_0001, 32'h7FFF_FFFE};
    logic [15:0] phase_timeout [6] = '{16'd1, 16'd65535, 16'd7, 16'd12, 16'd0, 16'd4};
    int          idle_mode [4] = '{0, 80, 0, 24};
    int          stall_mode [4] = '{0, 0, 80, 24};

    initial begin
        int n;
        int pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: ticks to timeout, idle bytes, start byte as body byte,
        // frame with extreme word bytes and a tick inside, bad third header byte
        set_config(32'hFFFF_FFFF, 16'd2);
        void'(push_tick());
        void'(push_tick());
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, START_BYTE);
        push_item(OP_BYTE, START_BYTE);
        push_item(OP_BYTE, START_BYTE);
        push_item(OP_BYTE, HDR_TEXT[0]);
        push_item(OP_BYTE, HDR_TEXT[1]);
        push_item(OP_BYTE, HDR_TEXT[2]);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        void'(push_tick());
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h00);
        push_item(OP_BYTE, 8'hFF);
        push_item(OP_BYTE, 8'h80);
        push_item(OP_BYTE, START_BYTE);
        push_item(OP_BYTE, HDR_TEXT[0]);
        push_item(OP_BYTE, HDR_TEXT[1]);
        push_item(OP_BYTE, 8'h3C);
        void'(push_tick());
        void'(push_tick());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            set_config(phase_default[ph], phase_timeout[ph]);
            idle_pct = idle_mode[ph % 4];
            stall_pct = stall_mode[ph % 4];
            if (ph == 4) begin
                fork
                    begin
                        hold_off <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            n = 0;
            while (n < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    n += push_frame(pick_word(), 3);
                end else if (pick < 78) begin
                    n += push_frame(pick_word(), $urandom_range(2));
                end else if (pick < 90) begin
                    repeat ($urandom_range(1, 14))
                        n += push_tick();
                end else begin
                    push_item(OP_BYTE, ($urandom_range(3) == 0) ? START_BYTE : 8'($urandom));
                    n++;
                end
            end
            drain();
        end

        if (mismatches == 0 && expected_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ remote_packet_receiver.f @@
+incdir+design
design/rpr_pkg.sv
design/rpr_regs.sv
design/rpr_core.sv
design/rpr_out_buf.sv
design/remote_packet_receiver.sv
design/rpr_checker.sv
tb/remote_packet_receiver_tb.sv
